@@ src/dmc_pkg.sv @@
package dmc_pkg;

    localparam int ADDR_W      = 32;
    localparam int WORD_W      = 8;
    localparam int OUT_LINE_W  = 10;
    localparam int TAG_W       = 31;
    localparam int CNT_W       = 32;
    localparam int TIME_W      = 40;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int OB_W        = 4;
    localparam int IB_W        = 4;
    localparam int TB_W        = 5;
    localparam int PEN_W       = 8;

    localparam logic [OB_W-1:0]   MAX_OFFSET_BITS   = 4'd8;
    localparam logic [OB_W-1:0]   RST_OFFSET_BITS   = 4'd2;
    localparam logic [IB_W-1:0]   RST_INDEX_BITS    = 4'd10;
    localparam logic [TB_W-1:0]   RST_TAG_BITS      = 5'd20;
    localparam logic [PEN_W-1:0]  RST_MISS_PENALTY  = 8'd10;
    localparam logic [CNT_W-1:0]  CNT_MAX           = '1;
    localparam logic [TIME_W-1:0] TIME_MAX          = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OFFSET_BITS  = 4'd0,
        REG_INDEX_BITS   = 4'd1,
        REG_TAG_BITS     = 4'd2,
        REG_MISS_PENALTY = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } line_entry_t;

endpackage

@@ src/dmc_req_if.sv @@
interface dmc_req_if;
    import dmc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

@@ src/dmc_rsp_if.sv @@
interface dmc_rsp_if;
    import dmc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [OUT_LINE_W-1:0] line_index;
    logic [TAG_W-1:0]      tag_value;
    logic [WORD_W-1:0]     word_offset;
    logic [CNT_W-1:0]      hits_so_far;
    logic [CNT_W-1:0]      misses_so_far;
    logic [TIME_W-1:0]     time_so_far;

    modport source (
        output valid, output hit, output line_index, output tag_value,
        output word_offset, output hits_so_far, output misses_so_far,
        output time_so_far, input ready
    );
    modport sink (
        input valid, input hit, input line_index, input tag_value,
        input word_offset, input hits_so_far, input misses_so_far,
        input time_so_far, output ready
    );
endinterface

@@ src/direct_mapped_cache_tag_check.sv @@
// Direct-mapped cache tag lookup with hit, miss and time statistics.
// Requests arrive on req (a word address) and each produces exactly one
// response on rsp with the hit flag, the address split into tag, line index
// and word offset, and the running hit, miss and time totals.
// The split is set through the write port (cfg_we, cfg_index, cfg_data);
// registers should only be written while no request is in flight.
// A request accepted at a clock edge is registered in the lookup stage, and its response
// is then registered in the output register, from which it is taken.
// One request per cycle is sustained while rsp.ready stays high after the sweep:
// the line is read from the tag memory as the request is accepted, compared and
// written back in the lookup stage, and a miss written back in the same cycle as
// the next request's read is forwarded to that request.
// After reset the tag memory is swept to clear the valid bits of all
// 2**floor(log2(MAX_LINES)) lines (1024 at the default); req.ready stays
// low until the sweep ends. Configuration writes are taken during the sweep.
// When rsp.ready is low the response is held in its output register, one
// more request is still taken into the lookup stage, and then req.ready
// drops until the response is taken.
module direct_mapped_cache_tag_check #(
    parameter int MAX_LINES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    dmc_req_if.sink                            req,
    dmc_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [dmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmc_pkg::*;

    localparam int LINE_W = $clog2(MAX_LINES + 1) - 1;

    logic [OB_W-1:0]       offset_bits_reg;
    logic [IB_W-1:0]       index_bits_reg;
    logic [TB_W-1:0]       tag_bits_reg;
    logic [PEN_W-1:0]      miss_penalty_reg;

    logic [OB_W-1:0]       ob;
    logic [IB_W:0]         ib;
    logic [ADDR_W-1:0]     sh_line;
    logic [ADDR_W-1:0]     sh_tag;
    logic [WORD_W-1:0]     word;
    logic [LINE_W-1:0]     line;
    logic [TAG_W-1:0]      tag;
    logic                  accept;
    logic                  mem_busy;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [LINE_W-1:0]     s1_line_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic [WORD_W-1:0]     s1_word_reg;
    logic                  fwd_en_reg;
    logic [LINE_W-1:0]     fwd_line_reg;
    logic [TAG_W-1:0]      fwd_tag_reg;
    logic                  s1_fire;

    line_entry_t           rd_data;
    line_entry_t           entry;
    line_entry_t           wr_data;
    logic                  hit;
    logic                  wr_en;

    logic [CNT_W-1:0]      hits_reg;
    logic [CNT_W-1:0]      hits_next;
    logic [CNT_W-1:0]      misses_reg;
    logic [CNT_W-1:0]      misses_next;
    logic [TIME_W-1:0]     time_reg;
    logic [TIME_W-1:0]     time_next;
    logic [TIME_W-1:0]     time_add;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_hit_reg;
    logic [OUT_LINE_W-1:0] out_line_reg;
    logic [TAG_W-1:0]      out_tag_reg;
    logic [WORD_W-1:0]     out_word_reg;
    logic [CNT_W-1:0]      out_hits_reg;
    logic [CNT_W-1:0]      out_misses_reg;
    logic [TIME_W-1:0]     out_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg  <= RST_OFFSET_BITS;
            index_bits_reg   <= RST_INDEX_BITS;
            tag_bits_reg     <= RST_TAG_BITS;
            miss_penalty_reg <= RST_MISS_PENALTY;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_OFFSET_BITS:  offset_bits_reg  <= cfg_data[OB_W-1:0];
                REG_INDEX_BITS:   index_bits_reg   <= cfg_data[IB_W-1:0];
                REG_TAG_BITS:     tag_bits_reg     <= cfg_data[TB_W-1:0];
                REG_MISS_PENALTY: miss_penalty_reg <= cfg_data[PEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Address split for the incoming request.
    always_comb
    begin
        ob = (offset_bits_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_reg;
        ib = ({1'b0, index_bits_reg} > (IB_W + 1)'(LINE_W)) ?
             (IB_W + 1)'(LINE_W) : {1'b0, index_bits_reg};
        sh_line = req.address >> ob;
        sh_tag  = req.address >> ((IB_W + 2)'(ob) + (IB_W + 2)'(ib));
        word    = req.address[WORD_W-1:0] & ~({WORD_W{1'b1}} << ob);
        line    = sh_line[LINE_W-1:0] & ~({LINE_W{1'b1}} << ib);
        tag     = sh_tag[TAG_W-1:0] & ~({TAG_W{1'b1}} << tag_bits_reg);
    end

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !mem_busy && (!s1_valid_reg || s1_fire);
    assign accept    = req.valid && req.ready;

    dmc_tag_mem #(
        .LINE_W (LINE_W)
    ) u_tag_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_line (line),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_line (s1_line_reg),
        .wr_data (wr_data),
        .busy    (mem_busy)
    );

    // A miss written at the edge that read this line is taken from the bypass.
    always_comb
    begin
        entry = rd_data;
        if (fwd_en_reg && (fwd_line_reg == s1_line_reg))
        begin
            entry.valid = 1'b1;
            entry.tag   = fwd_tag_reg;
        end
        hit           = entry.valid && (entry.tag == s1_tag_reg);
        wr_en         = s1_fire && !hit;
        wr_data.valid = 1'b1;
        wr_data.tag   = s1_tag_reg;
    end

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (hit)
        begin
            time_add = TIME_W'(1);
            if (hits_reg != CNT_MAX)
            begin
                hits_next = hits_reg + 1'b1;
            end
        end
        else
        begin
            time_add = TIME_W'(miss_penalty_reg);
            if (misses_reg != CNT_MAX)
            begin
                misses_next = misses_reg + 1'b1;
            end
        end
        time_next = (time_reg > (TIME_MAX - time_add)) ? TIME_MAX : (time_reg + time_add);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_en_reg    <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            time_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fwd_en_reg <= wr_en;
            end
            if (s1_fire)
            begin
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                time_reg   <= time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_line_reg  <= line;
            s1_tag_reg   <= tag;
            s1_word_reg  <= word;
            fwd_line_reg <= s1_line_reg;
            fwd_tag_reg  <= s1_tag_reg;
        end
        if (s1_fire)
        begin
            out_hit_reg    <= hit;
            out_line_reg   <= OUT_LINE_W'(s1_line_reg);
            out_tag_reg    <= s1_tag_reg;
            out_word_reg   <= s1_word_reg;
            out_hits_reg   <= hits_next;
            out_misses_reg <= misses_next;
            out_time_reg   <= time_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.line_index    = out_line_reg;
    assign rsp.tag_value     = out_tag_reg;
    assign rsp.word_offset   = out_word_reg;
    assign rsp.hits_so_far   = out_hits_reg;
    assign rsp.misses_so_far = out_misses_reg;
    assign rsp.time_so_far   = out_time_reg;

endmodule

@@ src/dmc_tag_mem.sv @@
module dmc_tag_mem #(
    parameter int LINE_W = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [LINE_W-1:0]    rd_line,
    output dmc_pkg::line_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [LINE_W-1:0]    wr_line,
    input  dmc_pkg::line_entry_t wr_data,
    output logic                 busy
);
    import dmc_pkg::*;

    localparam int DEPTH = 1 << LINE_W;

    line_entry_t       mem [0:DEPTH-1];
    line_entry_t       rd_data_reg;
    logic [LINE_W-1:0] clr_cnt_reg;
    logic [LINE_W-1:0] clr_cnt_next;
    logic              clr_active_reg;
    logic              clr_active_next;

    // After reset every line is swept once to clear its valid bit.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {LINE_W{1'b1}})
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clr_active_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            clr_active_reg <= clr_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_line] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_line];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

@@ src/dmc_checker.sv @@
module dmc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              rsp_hit,
    input logic [dmc_pkg::OUT_LINE_W-1:0]    rsp_line_index,
    input logic [dmc_pkg::TAG_W-1:0]         rsp_tag_value,
    input logic [dmc_pkg::WORD_W-1:0]        rsp_word_offset,
    input logic [dmc_pkg::CNT_W-1:0]         rsp_hits,
    input logic [dmc_pkg::CNT_W-1:0]         rsp_misses,
    input logic [dmc_pkg::TIME_W-1:0]        rsp_time
);
    import dmc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_hit, rsp_line_index,
        rsp_tag_value, rsp_word_offset, rsp_hits, rsp_misses, rsp_time}))
        else $error("Stalled response changed.");

    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("Response appeared without a request two cycles earlier.");

    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_hit ? (rsp_hits != '0) : (rsp_misses != '0)))
        else $error("Response outcome not reflected in its counter.");

    a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_time >= TIME_W'(rsp_hits))
        else $error("Time total below hit count.");

endmodule

bind direct_mapped_cache_tag_check dmc_checker u_dmc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_line_index  (rsp.line_index),
    .rsp_tag_value   (rsp.tag_value),
    .rsp_word_offset (rsp.word_offset),
    .rsp_hits        (rsp.hits_so_far),
    .rsp_misses      (rsp.misses_so_far),
    .rsp_time        (rsp.time_so_far)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import dmc_pkg::*;

    localparam int NUM_LINES      = 1024;
    localparam int LINE_BITS      = $clog2(NUM_LINES);
    localparam int PHASES         = 10;
    localparam int PHASE_REQUESTS = 145;
    localparam int IDLE_PERCENT   = 19;
    localparam int HOT_SLOTS      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE       = 4'd12;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SPARE = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_SPARE  = 4'd15;

    typedef struct packed {
        logic                  hit;
        logic [OUT_LINE_W-1:0] line_index;
        logic [TAG_W-1:0]      tag_value;
        logic [WORD_W-1:0]     word_offset;
        logic [CNT_W-1:0]      hits_so_far;
        logic [CNT_W-1:0]      misses_so_far;
        logic [TIME_W-1:0]     time_so_far;
    } access_result_t;

    typedef enum bit {
        ROW_ACCESS,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [ADDR_W-1:0]      value;
        bit                     typed;
        access_result_t         want;
    } step_row_t;

    localparam access_result_t NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 40;

    step_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ACCESS, '0, 32'h0000_0000, 1'b1,
          '{1'b0, 10'd0, 31'd0, 8'd0, 32'd0, 32'd1, 40'd10}},
        '{ROW_ACCESS, '0, 32'h0000_0003, 1'b1,
          '{1'b1, 10'd0, 31'd0, 8'd3, 32'd1, 32'd1, 40'd11}},
        '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 10'h3FF, 31'hFFFFF, 8'd3, 32'd1, 32'd2, 40'd21}},
        '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 10'h3FF, 31'hFFFFF, 8'd3, 32'd2, 32'd2, 40'd22}},
        '{ROW_ACCESS, '0, 32'h0000_0FFC, 1'b1,
          '{1'b0, 10'h3FF, 31'd0, 8'd0, 32'd2, 32'd3, 40'd32}},
        '{ROW_WRITE, REG_OFFSET_BITS, 32'h00, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_INDEX_BITS, 32'h00, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_TAG_BITS, 32'h00, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_MISS_PENALTY, 32'h00, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'hDEAD_BEEF, 1'b1,
          '{1'b1, 10'd0, 31'd0, 8'd0, 32'd3, 32'd3, 40'd33}},
        '{ROW_WRITE, REG_TAG_BITS, 32'hFF, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h1234_5678, 1'b1,
          '{1'b0, 10'd0, 31'h12345678, 8'd0, 32'd3, 32'd4, 40'd33}},
        '{ROW_ACCESS, '0, 32'h1234_5678, 1'b1,
          '{1'b1, 10'd0, 31'h12345678, 8'd0, 32'd4, 32'd4, 40'd34}},
        '{ROW_WRITE, REG_SPARE, 32'h00, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h9234_5678, 1'b1,
          '{1'b1, 10'd0, 31'h12345678, 8'd0, 32'd5, 32'd4, 40'd35}},
        '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 10'd0, 31'h7FFFFFFF, 8'd0, 32'd5, 32'd5, 40'd35}},
        '{ROW_WRITE, REG_OFFSET_BITS, 32'hF9, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_INDEX_BITS, 32'hFC, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_MISS_PENALTY, 32'hFF, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h0003_FF00, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_OFFSET_BITS, 32'h08, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_INDEX_BITS, 32'h01, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_TAG_BITS, 32'h01, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_MISS_PENALTY, 32'h01, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h0000_0100, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h0000_0300, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h0000_07FF, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_INDEX_BITS, 32'h0A, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_TAG_BITS, 32'h00, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h1234_5678, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h8765_4321, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_OFFSET_BITS, 32'h02, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_INDEX_BITS, 32'h0A, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_TAG_BITS, 32'h14, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_MISS_PENALTY, 32'h0A, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ACCESS, '0, 32'h0000_0FFC, 1'b0, NO_RESULT}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit                     steady_flow;

    logic [OB_W-1:0]  cur_offset_bits;
    logic [IB_W-1:0]  cur_index_bits;
    logic [TB_W-1:0]  cur_tag_bits;
    logic [PEN_W-1:0] cur_penalty;
    logic             line_ok [NUM_LINES];
    logic [TAG_W-1:0] line_tag_copy [NUM_LINES];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [TIME_W-1:0] time_count;

    access_result_t pending_results [$];
    int failures;
    int requests_sent;
    int responses_checked;
    int hits_seen;
    int settings_written;

    dmc_req_if req_ch ();
    dmc_rsp_if rsp_ch ();

    direct_mapped_cache_tag_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic access_result_t lookup_line(input logic [ADDR_W-1:0] addr);
        int ob;
        int ib;
        int tb;
        logic [63:0] wide;
        logic [OUT_LINE_W-1:0] line;
        logic [TAG_W-1:0] tag;
        logic [TIME_W-1:0] add;
        access_result_t r;
        ob = (cur_offset_bits > MAX_OFFSET_BITS) ? int'(MAX_OFFSET_BITS) : int'(cur_offset_bits);
        ib = (cur_index_bits > LINE_BITS) ? LINE_BITS : int'(cur_index_bits);
        tb = int'(cur_tag_bits);
        wide = {32'd0, addr};
        r.word_offset = WORD_W'(wide & ((64'd1 << ob) - 64'd1));
        line = OUT_LINE_W'((wide >> ob) & ((64'd1 << ib) - 64'd1));
        tag = TAG_W'((wide >> (ob + ib)) & ((64'd1 << tb) - 64'd1));
        r.hit = line_ok[line] && (line_tag_copy[line] == tag);
        if (r.hit)
        begin
            if (hit_count != CNT_MAX)
                hit_count = hit_count + 1'b1;
            add = 40'd1;
        end
        else
        begin
            line_ok[line] = 1'b1;
            line_tag_copy[line] = tag;
            if (miss_count != CNT_MAX)
                miss_count = miss_count + 1'b1;
            add = {32'd0, cur_penalty};
        end
        time_count = (time_count > TIME_MAX - add) ? TIME_MAX : time_count + add;
        r.line_index = line;
        r.tag_value = tag;
        r.hits_so_far = hit_count;
        r.misses_so_far = miss_count;
        r.time_so_far = time_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TIME_W-1:0] expected,
                                        input logic [TIME_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            failures++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (sel)
            REG_OFFSET_BITS:  cur_offset_bits = data[OB_W-1:0];
            REG_INDEX_BITS:   cur_index_bits = data[IB_W-1:0];
            REG_TAG_BITS:     cur_tag_bits = data[TB_W-1:0];
            REG_MISS_PENALTY: cur_penalty = data[PEN_W-1:0];
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic send_access(input logic [ADDR_W-1:0] addr, input bit typed,
                               input access_result_t want);
        access_result_t predicted;
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = lookup_line(addr);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Registers may only change once every request has produced its response.
    task automatic settle_pipeline();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin : response_check
        access_result_t got;
        access_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.hit, rsp_ch.line_index, rsp_ch.tag_value, rsp_ch.word_offset,
                    rsp_ch.hits_so_far, rsp_ch.misses_so_far, rsp_ch.time_so_far};
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding: line %0h tag %0h",
                       got.line_index, got.tag_value);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                responses_checked++;
                if (want.hit)
                    hits_seen++;
                check_field("hit", want.hit, got.hit);
                check_field("line_index", want.line_index, got.line_index);
                check_field("tag_value", want.tag_value, got.tag_value);
                check_field("word_offset", want.word_offset, got.word_offset);
                check_field("hits_so_far", want.hits_so_far, got.hits_so_far);
                check_field("misses_so_far", want.misses_so_far, got.misses_so_far);
                check_field("time_so_far", want.time_so_far, got.time_so_far);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] last_addr;
        logic [ADDR_W-1:0] next_addr;
        logic [ADDR_W-1:0] hot_addr [HOT_SLOTS];
        int pick;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.address = '0;
        steady_flow = 1'b0;
        cur_offset_bits = RST_OFFSET_BITS;
        cur_index_bits = RST_INDEX_BITS;
        cur_tag_bits = RST_TAG_BITS;
        cur_penalty = RST_MISS_PENALTY;
        foreach (line_ok[i])
        begin
            line_ok[i] = 1'b0;
            line_tag_copy[i] = '0;
        end
        hit_count = '0;
        miss_count = '0;
        time_count = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle_pipeline();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value[CFG_DATA_W-1:0]);
            end
            else
            begin
                send_access(directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        last_addr = '0;
        foreach (hot_addr[i])
            hot_addr[i] = $urandom;

        for (int p = 0; p < PHASES; p++)
        begin
            settle_pipeline();
            steady_flow = (p == 4);
            case (p)
                0:
                begin
                    write_reg(REG_OFFSET_BITS, 8'd0);
                    write_reg(REG_INDEX_BITS, 8'd1);
                    write_reg(REG_TAG_BITS, 8'd1);
                    write_reg(REG_MISS_PENALTY, 8'd1);
                end
                1:
                begin
                    write_reg(REG_OFFSET_BITS, 8'd8);
                    write_reg(REG_INDEX_BITS, 8'd10);
                    write_reg(REG_TAG_BITS, 8'd31);
                    write_reg(REG_MISS_PENALTY, 8'd255);
                end
                2:
                begin
                    write_reg(REG_OFFSET_BITS, 8'd2);
                    write_reg(REG_INDEX_BITS, 8'd3);
                    write_reg(REG_TAG_BITS, 8'd4);
                    write_reg(REG_MISS_PENALTY, 8'd50);
                end
                3:
                begin
                    write_reg(REG_OFFSET_BITS, 8'd15);
                    write_reg(REG_INDEX_BITS, 8'd15);
                    write_reg(REG_TAG_BITS, 8'd31);
                    write_reg(REG_MISS_PENALTY, 8'd0);
                end
                default:
                begin
                    write_reg(REG_OFFSET_BITS, CFG_DATA_W'($urandom_range(0, 255)));
                    write_reg(REG_INDEX_BITS, CFG_DATA_W'($urandom_range(0, 255)));
                    write_reg(REG_TAG_BITS, CFG_DATA_W'($urandom_range(0, 255)));
                    write_reg(REG_MISS_PENALTY, CFG_DATA_W'($urandom_range(0, 255)));
                end
            endcase
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)),
                          CFG_DATA_W'($urandom_range(0, 255)));
            repeat (4)
                hot_addr[$urandom_range(0, HOT_SLOTS - 1)] = $urandom;

            // Most requests revisit a small working set so that hits, conflicts
            // and back-to-back accesses to one line all occur under each split.
            for (int j = 0; j < PHASE_REQUESTS; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    next_addr = hot_addr[$urandom_range(0, HOT_SLOTS - 1)];
                else if (pick < 55)
                    next_addr = last_addr;
                else if (pick < 75)
                    next_addr = last_addr ^ (32'd1 << $urandom_range(0, 31));
                else if (pick < 90)
                    next_addr = hot_addr[$urandom_range(0, HOT_SLOTS - 1)] ^ $urandom_range(0, 255);
                else
                begin
                    next_addr = $urandom;
                    if ($urandom_range(0, 7) == 0)
                        hot_addr[$urandom_range(0, HOT_SLOTS - 1)] = next_addr;
                end
                send_access(next_addr, 1'b0, NO_RESULT);
                last_addr = next_addr;
            end
        end

        steady_flow = 1'b0;
        settle_pipeline();
        repeat (4) @(posedge clk);

        $display("Checked %0d responses to %0d requests (%0d hits, %0d misses).",
                 responses_checked, requests_sent, hits_seen, responses_checked - hits_seen);
        $display("Register writes: %0d, covering extreme, oversized and spare settings.",
                 settings_written);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
